[hdl/lstk_pkg.sv]
// Shared types and codes for the key/value LIFO stack.
package lstk_pkg;

    localparam int KEY_W   = 16;
    localparam int VAL_W   = 32;
    localparam int CNT_O_W = 7;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_FIND = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One stack entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // Per-command control broadcast to every cell
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             find;
        logic [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

[hdl/lifo_stack_with_key_extract_top.sv]
// Top level of the key/value LIFO stack with find-and-extract.
//
// Usage:
//   Drive i_command, i_key, i_value and raise start; the command transfers at
//   a rising edge where start is high and busy is low. busy stays low: a new
//   command can follow in every cycle.
//   Commands: push puts an entry on top, pop removes the top entry, find
//   removes the topmost entry whose key matches, keeping the order of the rest.
//   In the cycle after each transfer o_result_valid pulses for one cycle with the
//   status, the removed entry (zero when none), the entry count and the top
//   entry after the command. The receiver cannot stall; results are not held.
//   Throughput is one command per cycle: every slot is a cell that compares its
//   key and shifts one place in the same cycle, and the find hit and extracted
//   entry ripple through the row of cells.
//   Reset (synchronous, active low) empties the stack; slot contents are not
//   cleared, since only occupied slots are ever read.
module lifo_stack_with_key_extract_top #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_key,
    output logic [31:0] o_out_value,
    output logic [6:0]  o_entry_count,
    output logic        o_top_valid,
    output logic [15:0] o_top_key,
    output logic [31:0] o_top_value
);

    localparam int CW = $clog2(DEPTH + 1);

    lstk_pkg::t_cmd       w_cmd;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    lstk_pkg::t_cell_ctrl w_ctrl;
    lstk_pkg::t_entry     w_in_entry;
    lstk_pkg::t_entry     w_entry   [DEPTH];
    logic                 w_found   [DEPTH+1];
    lstk_pkg::t_entry     w_extract [DEPTH+1];
    lstk_pkg::t_status    n_status;
    lstk_pkg::t_entry     n_out;

    logic [CW-1:0]        r_count;
    logic                 r_valid;
    lstk_pkg::t_status    r_status;
    lstk_pkg::t_entry     r_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_cmd    = lstk_pkg::t_cmd'(i_command);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_in_entry.key   = i_key;
    assign w_in_entry.value = i_value;

    // Control broadcast to the cells
    assign w_ctrl.push = w_accept && (w_cmd == lstk_pkg::CMD_PUSH) && !w_full;
    assign w_ctrl.pop  = w_accept && (w_cmd == lstk_pkg::CMD_POP) && !w_empty;
    assign w_ctrl.find = w_accept && (w_cmd == lstk_pkg::CMD_FIND);
    assign w_ctrl.key  = i_key;

    assign w_found[0]   = 1'b0;
    assign w_extract[0] = '0;

    // Row of cells, slot 0 is the top
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lstk_pkg::t_entry w_above;
        lstk_pkg::t_entry w_below;
        logic             w_occ;

        if (g == 0) begin : g_top
            assign w_above = w_in_entry;
        end else begin : g_mid
            assign w_above = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_nbot
            assign w_below = w_entry[g+1];
        end
        assign w_occ = (CW'(g) < r_count);

        lstk_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occ),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .i_found      (w_found[g]),
            .i_extract    (w_extract[g]),
            .o_entry      (w_entry[g]),
            .o_found      (w_found[g+1]),
            .o_extract    (w_extract[g+1])
        );
    end

    // Result status and removed entry
    always_comb begin
        n_status = lstk_pkg::ST_OK;
        n_out    = '0;
        unique case (w_cmd)
            lstk_pkg::CMD_PUSH: begin
                if (w_full) begin
                    n_status = lstk_pkg::ST_FULL;
                end
            end
            lstk_pkg::CMD_POP: begin
                if (w_empty) begin
                    n_status = lstk_pkg::ST_MISS;
                end else begin
                    n_out = w_entry[0];
                end
            end
            lstk_pkg::CMD_FIND: begin
                if (w_found[DEPTH]) begin
                    n_out = w_extract[DEPTH];
                end else begin
                    n_status = lstk_pkg::ST_MISS;
                end
            end
            default: begin
                n_status = lstk_pkg::ST_OK;
            end
        endcase
    end

    // Fill count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_ctrl.push) begin
                r_count <= r_count + CW'(1);
            end else if (w_ctrl.pop || (w_ctrl.find && w_found[DEPTH])) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_out_key      = r_out.key;
    assign o_out_value    = r_out.value;
    assign o_entry_count  = 7'(r_count);
    assign o_top_valid    = !w_empty;
    assign o_top_key      = w_empty ? '0 : w_entry[0].key;
    assign o_top_value    = w_empty ? '0 : w_entry[0].value;

endmodule

[hdl/lstk_cell.sv]
// One stack slot: holds an entry, compares its key and shifts with its neighbors.
module lstk_cell (
    input  logic                i_clk,
    input  lstk_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  lstk_pkg::t_entry    i_from_above,
    input  lstk_pkg::t_entry    i_from_below,
    input  logic                i_found,
    input  lstk_pkg::t_entry    i_extract,
    output lstk_pkg::t_entry    o_entry,
    output logic                o_found,
    output lstk_pkg::t_entry    o_extract
);

    lstk_pkg::t_entry r_entry;
    logic             w_match;
    logic             w_first;
    logic             w_shift_up;

    // Key compare, only on slots that hold an entry
    assign w_match = i_occupied && (r_entry.key == i_ctrl.key);
    assign w_first = w_match && !i_found;

    // Found flag and extracted entry ripple from the top slot downward
    assign o_found   = i_found || w_match;
    assign o_extract = w_first ? r_entry : i_extract;

    // Slots at and below the first hit close the gap on a find
    assign w_shift_up = i_ctrl.pop || (i_ctrl.find && o_found);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_entry <= i_from_above;
        end else if (w_shift_up) begin
            r_entry <= i_from_below;
        end
    end

    assign o_entry = r_entry;

endmodule
